[design/urts_pkg.sv]
package urts_pkg;

	localparam int DATA_BITS = 8;
	localparam int BIT_CNT_W = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;

	localparam int FRAME_W = 4;
	localparam int BYTE_W  = 8;
	localparam int TICK_W  = 8;

	localparam logic [FRAME_W-1:0] CODE_IDLE       = FRAME_W'(0);
	localparam logic [FRAME_W-1:0] CODE_SYNC       = FRAME_W'(1);
	localparam logic [FRAME_W-1:0] CODE_FIRST_DATA = FRAME_W'(2);
	localparam logic [FRAME_W-1:0] CODE_STOP       = FRAME_W'(DATA_BITS + 2);

	localparam logic [TICK_W-1:0] BIT_PERIOD_RST = TICK_W'(3);

	localparam int PADDR_W = 3;
	localparam logic [PADDR_W-3:0] REG_BIT_PERIOD = '0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SYNC,
		ST_DATA,
		ST_STOP
	} rx_state_t;

endpackage

[design/uart_rx_tick_sampler.sv]
// An accepted tick's result enters the output register in the next cycle.
// Throughput: one tick per clock cycle; a stalled result holds the input off
// only while the output register is full and not being taken.
// Reset: asynchronous, active low; the receiver returns to idle with a cleared
// tick counter and shift register, and the bit period returns to three ticks.
module uart_rx_tick_sampler (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [urts_pkg::PADDR_W-1:0]        paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                rx_line,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [urts_pkg::FRAME_W-1:0]        frame_state,
	output logic [urts_pkg::BYTE_W-1:0]         rx_byte,
	output logic                                byte_done
);

	logic [urts_pkg::TICK_W-1:0]    bit_period_q;
	urts_pkg::rx_state_t            state_q, state_d;
	logic [urts_pkg::BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
	logic [urts_pkg::TICK_W-1:0]    tick_q, tick_d, tick_inc;
	logic [urts_pkg::BYTE_W-1:0]    shift_q, shift_d;
	logic                           done_d;
	logic [urts_pkg::FRAME_W-1:0]   code_d;
	logic                           accept;
	logic                           cfg_wr;
	logic                           last_bit;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign in_ready = !out_valid || out_ready;
	assign accept   = in_valid && in_ready;
	assign tick_inc = tick_q + urts_pkg::TICK_W'(1);
	assign last_bit = (bit_cnt_q == urts_pkg::BIT_CNT_W'(urts_pkg::DATA_BITS - 1));

	always_comb begin
		if (paddr[urts_pkg::PADDR_W-1:2] == urts_pkg::REG_BIT_PERIOD) begin
			prdata = {{(32 - urts_pkg::TICK_W){1'b0}}, bit_period_q};
		end else begin
			prdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q <= urts_pkg::BIT_PERIOD_RST;
		end else if (cfg_wr && paddr[urts_pkg::PADDR_W-1:2] == urts_pkg::REG_BIT_PERIOD) begin
			bit_period_q <= pwdata[urts_pkg::TICK_W-1:0];
		end
	end

	// Next state. A bit period of zero is reached only after the counter wraps.
	always_comb begin
		state_d   = state_q;
		bit_cnt_d = bit_cnt_q;
		tick_d    = tick_q;
		shift_d   = shift_q;
		done_d    = 1'b0;
		case (state_q)
			urts_pkg::ST_IDLE: begin
				if (!rx_line) begin
					state_d = urts_pkg::ST_SYNC;
				end
			end
			urts_pkg::ST_SYNC: begin
				tick_d    = '0;
				bit_cnt_d = '0;
				state_d   = urts_pkg::ST_DATA;
			end
			urts_pkg::ST_DATA: begin
				tick_d = tick_inc;
				if (tick_inc == bit_period_q) begin
					tick_d  = '0;
					shift_d = {rx_line, shift_q[urts_pkg::BYTE_W-1:1]};
					if (last_bit) begin
						state_d = urts_pkg::ST_STOP;
						done_d  = 1'b1;
					end else begin
						bit_cnt_d = bit_cnt_q + urts_pkg::BIT_CNT_W'(1);
					end
				end
			end
			urts_pkg::ST_STOP: begin
				if (rx_line) begin
					state_d = urts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = urts_pkg::ST_IDLE;
			end
		endcase
	end

	// Reported frame code for the state after this tick.
	always_comb begin
		case (state_d)
			urts_pkg::ST_IDLE: code_d = urts_pkg::CODE_IDLE;
			urts_pkg::ST_SYNC: code_d = urts_pkg::CODE_SYNC;
			urts_pkg::ST_DATA: begin
				code_d = urts_pkg::CODE_FIRST_DATA
					+ urts_pkg::FRAME_W'(bit_cnt_d);
			end
			urts_pkg::ST_STOP: code_d = urts_pkg::CODE_STOP;
			default:           code_d = urts_pkg::CODE_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= urts_pkg::ST_IDLE;
			bit_cnt_q <= '0;
			tick_q    <= '0;
			shift_q   <= '0;
		end else if (accept) begin
			state_q   <= state_d;
			bit_cnt_q <= bit_cnt_d;
			tick_q    <= tick_d;
			shift_q   <= shift_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			frame_state <= code_d;
			rx_byte     <= shift_d;
			byte_done   <= done_d;
		end
	end

endmodule

[design/urts_chk.sv]
module urts_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [urts_pkg::FRAME_W-1:0] frame_state,
	input logic [urts_pkg::BYTE_W-1:0]  rx_byte,
	input logic                         byte_done
);

	// A finished byte is always reported together with the stop code.
	a_done_in_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_done |-> frame_state == urts_pkg::CODE_STOP)
		else $error("byte_done without stop code");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_state <= urts_pkg::CODE_STOP)
		else $error("frame code out of range");

	// An empty output register never holds the input off.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

	// Every accepted tick produces a result on the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted transaction produced no result");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rx_byte)
			&& $stable(frame_state) && $stable(byte_done))
		else $error("stalled result changed");

endmodule

bind uart_rx_tick_sampler urts_chk chk_i (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.frame_state (frame_state),
	.rx_byte     (rx_byte),
	.byte_done   (byte_done)
);

[dv/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RAND_TICKS    = 800;
	localparam int QUIET_TICKS   = 150;
	localparam int LONG_HOLD     = 200;
	localparam int WATCHDOG      = 2000;
	localparam int N_DIRECTED    = 24;
	localparam logic [urts_pkg::PADDR_W-1:0] ADDR_PERIOD = {urts_pkg::REG_BIT_PERIOD, 2'b00};
	localparam logic [urts_pkg::PADDR_W-1:0] ADDR_SPARE  = {~urts_pkg::REG_BIT_PERIOD, 2'b00};

	typedef struct packed {
		logic [urts_pkg::FRAME_W-1:0] state;
		logic [urts_pkg::BYTE_W-1:0]  data;
		logic                         done;
	} rx_view_t;

	typedef struct {
		bit       typed;
		rx_view_t want;
	} tick_tag_t;

	typedef struct {
		logic     line;
		bit       typed;
		rx_view_t want;
	} dir_row_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          psel      = 1'b0;
	logic                          penable   = 1'b0;
	logic                          pwrite    = 1'b0;
	logic [urts_pkg::PADDR_W-1:0]  paddr     = '0;
	logic [31:0]                   pwdata    = '0;
	logic [31:0]                   prdata;
	logic                          pready;
	logic                          in_valid  = 1'b0;
	logic                          in_ready;
	logic                          rx_line   = 1'b1;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [urts_pkg::FRAME_W-1:0]  frame_state;
	logic [urts_pkg::BYTE_W-1:0]   rx_byte;
	logic                          byte_done;

	uart_rx_tick_sampler dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .rx_line(rx_line),
		.out_valid(out_valid), .out_ready(out_ready),
		.frame_state(frame_state), .rx_byte(rx_byte), .byte_done(byte_done)
	);

	// Receiver model state, kept alongside the block.
	logic [urts_pkg::TICK_W-1:0]  mdl_period = urts_pkg::BIT_PERIOD_RST;
	logic [urts_pkg::FRAME_W-1:0] mdl_state  = urts_pkg::CODE_IDLE;
	logic [urts_pkg::TICK_W-1:0]  mdl_ticks  = '0;
	logic [urts_pkg::BYTE_W-1:0]  mdl_shift  = '0;

	rx_view_t  expected_ticks[$];
	tick_tag_t tick_tags[$];

	int  faults      = 0;
	int  items_sent  = 0;
	int  bytes_seen  = 0;
	int  settings    = 0;
	int  idle_cycles = 0;
	bit  calm        = 1'b0;
	bit  hold_req    = 1'b0;

	rx_view_t  mon_pred;
	rx_view_t  mon_want;
	tick_tag_t mon_tag;

	dir_row_t dir_rows[N_DIRECTED] = '{
		'{1'b1, 1'b1, '{urts_pkg::CODE_IDLE,       8'h00, 1'b0}},
		'{1'b0, 1'b1, '{urts_pkg::CODE_SYNC,       8'h00, 1'b0}},
		'{1'b1, 1'b1, '{urts_pkg::CODE_FIRST_DATA, 8'h00, 1'b0}},
		'{1'b1, 1'b0, '0},
		'{1'b1, 1'b0, '0},
		'{1'b1, 1'b0, '0},
		'{1'b1, 1'b0, '0},
		'{1'b1, 1'b0, '0},
		'{1'b1, 1'b0, '0},
		'{1'b1, 1'b0, '0},
		'{1'b1, 1'b1, '{urts_pkg::CODE_STOP,       8'hFF, 1'b1}},
		'{1'b0, 1'b1, '{urts_pkg::CODE_STOP,       8'hFF, 1'b0}},
		'{1'b1, 1'b1, '{urts_pkg::CODE_IDLE,       8'hFF, 1'b0}},
		'{1'b0, 1'b0, '0},
		'{1'b0, 1'b0, '0},
		'{1'b0, 1'b0, '0},
		'{1'b0, 1'b0, '0},
		'{1'b0, 1'b0, '0},
		'{1'b0, 1'b0, '0},
		'{1'b0, 1'b0, '0},
		'{1'b0, 1'b0, '0},
		'{1'b0, 1'b0, '0},
		'{1'b0, 1'b1, '{urts_pkg::CODE_STOP,       8'h00, 1'b1}},
		'{1'b1, 1'b1, '{urts_pkg::CODE_IDLE,       8'h00, 1'b0}}
	};

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// One tick of the receiver: the view after this tick's update.
	function automatic rx_view_t step_receiver(logic line);
		rx_view_t r;
		r.done = 1'b0;
		if (mdl_state == urts_pkg::CODE_IDLE) begin
			if (!line)
				mdl_state = urts_pkg::CODE_SYNC;
		end else if (mdl_state == urts_pkg::CODE_SYNC) begin
			mdl_ticks = '0;
			mdl_state = urts_pkg::CODE_FIRST_DATA;
		end else if (mdl_state < urts_pkg::CODE_STOP) begin
			// The counter wraps, so a period of zero takes 256 ticks.
			mdl_ticks = mdl_ticks + 1'b1;
			if (mdl_ticks == mdl_period) begin
				mdl_ticks = '0;
				mdl_shift = {line, mdl_shift[urts_pkg::BYTE_W-1:1]};
				mdl_state = mdl_state + 1'b1;
				r.done = (mdl_state == urts_pkg::CODE_STOP);
			end
		end else if (line) begin
			mdl_state = urts_pkg::CODE_IDLE;
		end
		r.state = mdl_state;
		r.data  = mdl_shift;
		return r;
	endfunction

	task automatic send_tick(input logic line, input bit typed = 1'b0,
			input rx_view_t want = '0);
		tick_tag_t tag;
		tag.typed = typed;
		tag.want  = want;
		tick_tags.push_back(tag);
		if (!calm && $urandom_range(0, 11) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_line  <= line;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// Stops offering ticks and waits until every result has been taken.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_ticks.size() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [urts_pkg::PADDR_W-1:0] addr,
			input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_PERIOD)
			mdl_period = data[urts_pkg::TICK_W-1:0];
	endtask

	task automatic check_period_reg();
		logic [31:0] got;
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		paddr   <= ADDR_PERIOD;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== {{(32-urts_pkg::TICK_W){1'b0}}, mdl_period}) begin
			faults++;
			if (faults <= 10)
				$display("bit period read: expected %0d, got %0d", mdl_period, got);
		end
	endtask

	task automatic set_period(input logic [urts_pkg::TICK_W-1:0] per);
		drain_results();
		cfg_write(ADDR_PERIOD, ($urandom() & 32'hFFFF_FF00) | per);
		check_period_reg();
		settings++;
	endtask

	// A frame: start bit, the sync tick, the data cells (eight unless cut short),
	// then the stop bit. A messy frame has its cells corrupted and its stop bit
	// held low a while.
	task automatic send_frame(input logic [7:0] data, input bit messy,
			input int cells = 8);
		int   per;
		int   i;
		int   k;
		logic v;
		per = (mdl_period == 0) ? 256 : int'(mdl_period);
		repeat ($urandom_range(0, 3)) send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'($urandom_range(0, 1)));
		for (i = 0; i < cells; i++) begin
			for (k = 1; k <= per; k++) begin
				v = data[i];
				if (messy && $urandom_range(0, 7) == 0)
					v = ~v;
				send_tick(v);
			end
		end
		if (messy)
			repeat ($urandom_range(1, 5)) send_tick(1'b0);
		send_tick(1'b1);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			// Results are taken before this edge's input is predicted, so a
			// result can never be matched with its own transaction.
			if (out_valid && out_ready) begin
				if (expected_ticks.size() == 0) begin
					faults++;
					if (faults <= 10)
						$display("unexpected result: state %0d byte %02h done %0b",
							frame_state, rx_byte, byte_done);
				end else begin
					mon_want = expected_ticks.pop_front();
					if (frame_state !== mon_want.state || rx_byte !== mon_want.data ||
							byte_done !== mon_want.done) begin
						faults++;
						if (faults <= 10)
							$display("mismatch: expected state %0d byte %02h done %0b, ",
								mon_want.state, mon_want.data, mon_want.done,
								"got state %0d byte %02h done %0b",
								frame_state, rx_byte, byte_done);
					end
					if (byte_done === 1'b1)
						bytes_seen++;
				end
			end
			if (in_valid && in_ready) begin
				mon_pred = step_receiver(rx_line);
				mon_tag  = tick_tags.pop_front();
				expected_ticks.push_back(mon_tag.typed ? mon_tag.want : mon_pred);
			end
			if (idle_cycles >= WATCHDOG) begin
				$display("watchdog: no transaction for %0d cycles", WATCHDOG);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				// Long hold-off so that the output register fills and the input stalls.
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
				out_ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int i;
		int phase;
		int f;
		int nfr;
		int kind;
		int goal;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		check_period_reg();
		set_period(8'd1);
		for (i = 0; i < N_DIRECTED; i++)
			send_tick(dir_rows[i].line, dir_rows[i].typed, dir_rows[i].want);
		drain_results();
		// A write to an address with no register must leave the period alone.
		cfg_write(ADDR_SPARE, $urandom());
		check_period_reg();

		goal  = items_sent + RAND_TICKS;
		phase = 0;
		while (items_sent < goal) begin
			set_period(($urandom_range(0, 4) == 0) ? 8'd1 : 8'($urandom_range(2, 6)));
			calm = ($urandom_range(0, 3) == 0);
			nfr  = $urandom_range(3, 6);
			for (f = 0; f < nfr; f++) begin
				if (phase == 0 && f == 0)
					hold_req = 1'b1;
				if (phase == 1 && f == 1)
					drain_results();
				kind = $urandom_range(0, 9);
				if (kind < 7)
					send_frame(8'($urandom_range(0, 255)), 1'b0);
				else if (kind < 9)
					send_frame(8'($urandom_range(0, 255)), 1'b1);
				else
					repeat ($urandom_range(1, 20)) send_tick(1'($urandom_range(0, 1)));
			end
			phase++;
		end

		// The longest periods get one data cell each; the receiver is left mid-frame
		// and simply runs on through the ticks that follow.
		calm = 1'b0;
		set_period(8'd255);
		send_frame(8'($urandom_range(0, 255)), 1'b0, 1);
		set_period(8'd0);
		send_frame(8'($urandom_range(0, 255)), 1'b0, 1);

		calm = 1'b1;
		set_period(8'($urandom_range(1, 4)));
		goal = items_sent + QUIET_TICKS;
		while (items_sent < goal)
			send_frame(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));

		drain_results();
		repeat (4) @(posedge clk);
		$display("Sent %0d ticks over %0d bit-period settings, 255 and zero among them,",
			items_sent, settings);
		$display("with %0d received bytes flagged and %0d faults.", bytes_seen, faults);
		if (faults == 0 && expected_ticks.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[uart_rx_tick_sampler.f]
design/urts_pkg.sv
design/uart_rx_tick_sampler.sv
design/urts_chk.sv
dv/testbench.sv
